[hdl/alf_pkg.sv]
// alf_pkg: widths, mode codes, recurrence constants and shared types for the
// additive lagged Fibonacci generator. No dependencies.
package alf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int POS_W       = 6;
    localparam int WORD_W      = 32;
    localparam int NUM_W       = 31;
    localparam int MODE_W      = 2;

    // table split over a row of equal cells
    localparam int CELL_WORDS = 8;
    localparam int NUM_CELLS  = TABLE_DEPTH / CELL_WORDS;
    localparam int OFS_W      = $clog2(CELL_WORDS);
    localparam int CELL_ID_W  = POS_W - OFS_W;

    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SETPOS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd2;

    localparam logic [NUM_W-1:0] LCG_MUL = 31'd1103515245;
    localparam logic [NUM_W-1:0] LCG_ADD = 31'd12345;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_TABLE_LEN = 1'b0;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic  en;
        t_pos  addr;
        t_word data;
    } t_wr_req;

    typedef struct packed {
        logic en;
        t_pos lead;
        t_pos lag;
    } t_rd_req;

    // step a position, wrapping to zero when it lands on the table length
    function automatic t_pos advance(input t_pos pos, input t_pos len);
        t_pos nx;
        nx = pos + 1'b1;
        return (nx == len) ? '0 : nx;
    endfunction

endpackage

[hdl/alf_if.sv]
// alf_if: valid/ready channel interfaces for the command and result words.
// Depends on alf_pkg.
interface alf_in_if;
    logic                        valid;
    logic                        ready;
    logic [alf_pkg::MODE_W-1:0]  mode;
    alf_pkg::t_pos               index;
    alf_pkg::t_word              word;
    alf_pkg::t_pos               lag_set;

    modport source (output valid, mode, index, word, lag_set, input ready);
    modport sink   (input valid, mode, index, word, lag_set, output ready);
endinterface

interface alf_out_if;
    logic                       valid;
    logic                       ready;
    logic [alf_pkg::NUM_W-1:0]  number;
    alf_pkg::t_pos              lead_now;
    alf_pkg::t_pos              lag_now;

    modport source (output valid, number, lead_now, lag_now, input ready);
    modport sink   (input valid, number, lead_now, lag_now, output ready);
endinterface

[hdl/additive_lagged_fibonacci_rng.sv]
// additive_lagged_fibonacci_rng: top level. Position registers, table read,
// add / congruential step and write-back, output register, APB register.
// Depends on alf_pkg, alf_if, alf_table.
//
//   channel   dir   handshake          payload
//   i_in      in    valid/ready        mode, index, word, lag_set
//   o_out     out   valid/ready        number, lead_now, lag_now
//   apb       in    psel/penable       paddr, pwdata -> prdata (table_len @ 0x0)
//
// An accepted word passes the table read stage, then the output register; one
// word per cycle is sustained while o_out does not stall, draws included.
// The draw loop is table read -> add (or multiply-add) -> write, with the
// previous write forwarded when the next draw reads the same word.
// Reset (i_rst_n low, synchronous) clears positions, table_len and every
// cell's valid bits, so the table reads as zero at once; no clearing pass.
// A stalled o_out holds the output register; one more word still enters the
// read stage before i_in.ready drops.
module additive_lagged_fibonacci_rng (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    alf_in_if.sink                              i_in,
    alf_out_if.source                           o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [alf_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [alf_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [alf_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    // ---------------- config register ----------------
    alf_pkg::t_pos r_table_len;
    logic          cfg_wr;
    logic          cfg_sel;
    logic          lcg_mode;

    assign cfg_sel  = paddr[alf_pkg::CFG_ADDR_W-1:2] == alf_pkg::REG_TABLE_LEN;
    assign cfg_wr   = psel && penable && pwrite && cfg_sel;
    assign pready   = 1'b1;
    assign prdata   = cfg_sel ? alf_pkg::CFG_DATA_W'(r_table_len) : '0;
    assign lcg_mode = r_table_len == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_len <= '0;
        end else if (cfg_wr) begin
            r_table_len <= pwdata[alf_pkg::POS_W-1:0];
        end
    end

    // ---------------- stage registers ----------------
    alf_pkg::t_pos                  r_lead;
    alf_pkg::t_pos                  r_lag;

    logic                           r_b_valid;
    logic [alf_pkg::MODE_W-1:0]     r_b_mode;
    alf_pkg::t_pos                  r_b_index;
    alf_pkg::t_word                 r_b_word;
    alf_pkg::t_pos                  r_b_rd_lead;   // draw: word read and rewritten
    alf_pkg::t_pos                  r_b_lead_now;
    alf_pkg::t_pos                  r_b_lag_now;
    logic                           r_b_fwd_lead;
    logic                           r_b_fwd_lag;
    alf_pkg::t_word                 r_fwd_data;    // last word written to the table

    logic                           r_o_valid;
    logic [alf_pkg::NUM_W-1:0]      r_o_number;
    alf_pkg::t_pos                  r_o_lead;
    alf_pkg::t_pos                  r_o_lag;

    // ---------------- accept side ----------------
    logic               in_acc;
    logic               b_adv;
    logic               is_draw;
    alf_pkg::t_pos      n_lead;
    alf_pkg::t_pos      n_lag;
    alf_pkg::t_rd_req   rd_req;
    alf_pkg::t_wr_req   wr_req;

    assign b_adv       = r_b_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready  = !r_b_valid || b_adv;
    assign in_acc      = i_in.valid && i_in.ready;
    assign is_draw     = i_in.mode == alf_pkg::MODE_DRAW;

    always_comb begin
        n_lead = r_lead;
        n_lag  = r_lag;
        case (i_in.mode)
            alf_pkg::MODE_SETPOS: begin
                n_lead = i_in.index;
                n_lag  = i_in.lag_set;
            end
            alf_pkg::MODE_DRAW: begin
                if (!lcg_mode) begin
                    n_lead = alf_pkg::advance(r_lead, r_table_len);
                    n_lag  = alf_pkg::advance(r_lag, r_table_len);
                end
            end
            default: begin
            end
        endcase
    end

    // congruential mode works on word 0 only
    assign rd_req.en   = in_acc && is_draw;
    assign rd_req.lead = lcg_mode ? '0 : r_lead;
    assign rd_req.lag  = r_lag;

    // ---------------- read stage: compute and write back ----------------
    alf_pkg::t_word             tbl_lead;
    alf_pkg::t_word             tbl_lag;
    alf_pkg::t_word             lead_data;
    alf_pkg::t_word             lag_data;
    alf_pkg::t_word             sum;
    logic [alf_pkg::NUM_W-1:0]  lcg_x;
    logic                       b_wr_en;
    alf_pkg::t_pos              b_wr_addr;
    alf_pkg::t_word             b_wdata;
    logic [alf_pkg::NUM_W-1:0]  b_number;

    alf_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr_req),
        .i_rd        (rd_req),
        .o_lead_word (tbl_lead),
        .o_lag_word  (tbl_lag)
    );

    assign lead_data = r_b_fwd_lead ? r_fwd_data : tbl_lead;
    assign lag_data  = r_b_fwd_lag ? r_fwd_data : tbl_lag;
    assign sum       = lead_data + lag_data;
    // all operands 31 bits wide: product wraps mod 2^31
    assign lcg_x     = alf_pkg::NUM_W'(alf_pkg::LCG_MUL * lead_data[alf_pkg::NUM_W-1:0]
                                       + alf_pkg::LCG_ADD);

    assign b_wr_en   = r_b_valid && (r_b_mode == alf_pkg::MODE_WRITE
                                     || r_b_mode == alf_pkg::MODE_DRAW);
    assign b_wr_addr = (r_b_mode == alf_pkg::MODE_WRITE) ? r_b_index : r_b_rd_lead;

    always_comb begin
        b_wdata  = r_b_word;
        b_number = '0;
        if (r_b_mode == alf_pkg::MODE_DRAW) begin
            if (lcg_mode) begin
                b_wdata  = alf_pkg::WORD_W'(lcg_x);
                b_number = lcg_x;
            end else begin
                b_wdata  = sum;
                b_number = sum[alf_pkg::WORD_W-1:1];
            end
        end
    end

    assign wr_req.en   = b_adv && b_wr_en;
    assign wr_req.addr = b_wr_addr;
    assign wr_req.data = b_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead       <= '0;
            r_lag        <= '0;
            r_b_valid    <= 1'b0;
            r_b_fwd_lead <= 1'b0;
            r_b_fwd_lag  <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_lead <= n_lead;
                r_lag  <= n_lag;
                // the word leaving the read stage writes at this same edge
                r_b_fwd_lead <= wr_req.en && (b_wr_addr == rd_req.lead);
                r_b_fwd_lag  <= wr_req.en && (b_wr_addr == rd_req.lag);
            end else if (b_adv) begin
                r_b_fwd_lead <= 1'b0;
                r_b_fwd_lag  <= 1'b0;
            end
            if (in_acc) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_mode     <= i_in.mode;
            r_b_index    <= i_in.index;
            r_b_word     <= i_in.word;
            r_b_rd_lead  <= rd_req.lead;
            r_b_lead_now <= n_lead;
            r_b_lag_now  <= n_lag;
        end
        if (wr_req.en) begin
            r_fwd_data <= b_wdata;
        end
        if (b_adv) begin
            r_o_number <= b_number;
            r_o_lead   <= r_b_lead_now;
            r_o_lag    <= r_b_lag_now;
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.number   = r_o_number;
    assign o_out.lead_now = r_o_lead;
    assign o_out.lag_now  = r_o_lag;

    // ---------------- assertions ----------------
    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_fwd_lead || r_b_fwd_lag) |-> r_b_valid)
        else $error("forward flag set with empty read stage");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_b_valid |-> i_in.ready)
        else $error("input stalled with empty read stage");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_draw && !lcg_mode && r_lead < r_table_len)
        |=> r_lead < r_table_len)
        else $error("lead position left the table on a draw");

    a_lcg_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_draw && lcg_mode) |=> ($stable(r_lead) && $stable(r_lag)))
        else $error("positions moved in congruential mode");

endmodule

[hdl/alf_cell.sv]
// alf_cell: one slice of the table (CELL_WORDS words) with per-word valid bits,
// two registered read ports and the pass-along read chain. Depends on alf_pkg.
module alf_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [alf_pkg::CELL_ID_W-1:0]   i_cell_id,
    input  alf_pkg::t_wr_req                i_wr,
    input  alf_pkg::t_rd_req                i_rd,
    input  alf_pkg::t_word                  i_lead_chain,
    input  alf_pkg::t_word                  i_lag_chain,
    output alf_pkg::t_word                  o_lead_chain,
    output alf_pkg::t_word                  o_lag_chain
);

    alf_pkg::t_word                    r_mem [alf_pkg::CELL_WORDS];
    logic [alf_pkg::CELL_WORDS-1:0]    r_valid;
    alf_pkg::t_word                    r_lead_word;
    alf_pkg::t_word                    r_lag_word;
    logic                              r_lead_hit;
    logic                              r_lag_hit;

    logic                              wr_hit;
    logic [alf_pkg::OFS_W-1:0]         wr_ofs;
    logic [alf_pkg::OFS_W-1:0]         lead_ofs;
    logic [alf_pkg::OFS_W-1:0]         lag_ofs;
    logic                              lead_sel;
    logic                              lag_sel;

    assign wr_ofs   = i_wr.addr[alf_pkg::OFS_W-1:0];
    assign lead_ofs = i_rd.lead[alf_pkg::OFS_W-1:0];
    assign lag_ofs  = i_rd.lag[alf_pkg::OFS_W-1:0];
    assign wr_hit   = i_wr.en && (i_wr.addr[alf_pkg::POS_W-1:alf_pkg::OFS_W] == i_cell_id);
    assign lead_sel = i_rd.lead[alf_pkg::POS_W-1:alf_pkg::OFS_W] == i_cell_id;
    assign lag_sel  = i_rd.lag[alf_pkg::POS_W-1:alf_pkg::OFS_W] == i_cell_id;

    // storage: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[wr_ofs] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_lead_word <= r_mem[lead_ofs];
            r_lag_word  <= r_mem[lag_ofs];
        end
    end

    // never-written words read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_lead_hit <= 1'b0;
            r_lag_hit  <= 1'b0;
        end else begin
            if (wr_hit) begin
                r_valid[wr_ofs] <= 1'b1;
            end
            if (i_rd.en) begin
                r_lead_hit <= lead_sel && r_valid[lead_ofs];
                r_lag_hit  <= lag_sel && r_valid[lag_ofs];
            end
        end
    end

    assign o_lead_chain = r_lead_hit ? r_lead_word : i_lead_chain;
    assign o_lag_chain  = r_lag_hit ? r_lag_word : i_lag_chain;

endmodule

[hdl/alf_table.sv]
// alf_table: row of alf_cell slices; read data is handed cell to cell down the
// chain and the owning cell drops its word in. Depends on alf_pkg, alf_cell.
module alf_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  alf_pkg::t_wr_req  i_wr,
    input  alf_pkg::t_rd_req  i_rd,
    output alf_pkg::t_word    o_lead_word,
    output alf_pkg::t_word    o_lag_word
);

    alf_pkg::t_word lead_chain [alf_pkg::NUM_CELLS+1];
    alf_pkg::t_word lag_chain  [alf_pkg::NUM_CELLS+1];

    assign lead_chain[0] = '0;
    assign lag_chain[0]  = '0;

    for (genvar g = 0; g < alf_pkg::NUM_CELLS; g++) begin : g_cell
        alf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cell_id    (alf_pkg::CELL_ID_W'(g)),
            .i_wr         (i_wr),
            .i_rd         (i_rd),
            .i_lead_chain (lead_chain[g]),
            .i_lag_chain  (lag_chain[g]),
            .o_lead_chain (lead_chain[g+1]),
            .o_lag_chain  (lag_chain[g+1])
        );
    end

    assign o_lead_word = lead_chain[alf_pkg::NUM_CELLS];
    assign o_lag_word  = lag_chain[alf_pkg::NUM_CELLS];

endmodule

[verif/tb_additive_lagged_fibonacci_rng.sv]
// Testbench for additive_lagged_fibonacci_rng: directed and random command words
// with bursty input and stalling output, checked against an in-bench predictor.
// Depends on alf_pkg, alf_if and the RTL top level.
module tb_additive_lagged_fibonacci_rng;
    timeunit 1ns;
    timeprecision 1ps;

    // mode 3 has no name in the package; the block ignores it
    localparam logic [alf_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    // congruential step, kept at 32 bits and masked to 31 afterwards
    localparam logic [31:0] MUL_K = 32'd1103515245;
    localparam logic [31:0] INC_K = 32'd12345;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        logic [alf_pkg::MODE_W-1:0] mode;
        alf_pkg::t_pos              index;
        alf_pkg::t_word             word;
        alf_pkg::t_pos              lag_set;
    } t_gen_cmd;

    typedef struct {
        logic [alf_pkg::NUM_W-1:0] number;
        alf_pkg::t_pos             lead_now;
        alf_pkg::t_pos             lag_now;
    } t_gen_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [alf_pkg::CFG_ADDR_W-1:0] paddr;
    logic [alf_pkg::CFG_DATA_W-1:0] pwdata;
    logic [alf_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    alf_in_if  cmd_if ();
    alf_out_if res_if ();

    additive_lagged_fibonacci_rng dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: shadow table, both positions and the table length.
    logic [alf_pkg::WORD_W-1:0] word_tbl [alf_pkg::TABLE_DEPTH];
    alf_pkg::t_pos              lead_pos;
    alf_pkg::t_pos              lag_pos;
    alf_pkg::t_pos              len_cfg;

    t_gen_cmd    cmd_q [$];     // command words not yet taken by the block
    t_gen_result due_q [$];     // predicted result words, oldest first

    int  fail_cnt  = 0;
    int  cycle_cnt = 0;
    logic in_taken;

    // Sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver stall shaping
    int         style      = 0;
    int         style_left = 0;
    int         hold_left  = 0;
    logic       hold_val   = 1'b1;
    logic [7:0] stall_pat  = 8'b1011_0110;
    logic       rdy_nxt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A position steps by one mod 64 and returns to zero only when it lands
    // exactly on the table length, so one set past the length runs up to 63,
    // wraps, and then cycles normally.
    function automatic alf_pkg::t_pos next_pos(input alf_pkg::t_pos p);
        alf_pkg::t_pos nx;
        nx = p + 1'b1;
        return (nx == len_cfg) ? '0 : nx;
    endfunction

    // One command word through the generator; updates the shadow state.
    function automatic t_gen_result step_generator(input t_gen_cmd c);
        t_gen_result r;
        logic [31:0] sum;
        r.number = '0;
        case (c.mode)
            alf_pkg::MODE_WRITE: word_tbl[c.index] = c.word;
            alf_pkg::MODE_SETPOS: begin
                lead_pos = c.index;
                lag_pos  = c.lag_set;
            end
            alf_pkg::MODE_DRAW: begin
                if (len_cfg == 0) begin
                    // congruential mode: word 0 steps, positions stay put
                    sum         = MUL_K * word_tbl[0] + INC_K;
                    sum[31]     = 1'b0;
                    word_tbl[0] = sum;
                    r.number    = sum[30:0];
                end else begin
                    // both reads before the write, so lead == lag doubles
                    sum                = word_tbl[lead_pos] + word_tbl[lag_pos];
                    word_tbl[lead_pos] = sum;
                    r.number           = sum[31:1];
                    lead_pos           = next_pos(lead_pos);
                    lag_pos            = next_pos(lag_pos);
                end
            end
            default: ;
        endcase
        r.lead_now = lead_pos;
        r.lag_now  = lag_pos;
        return r;
    endfunction

    function automatic t_gen_cmd mk_cmd(input logic [alf_pkg::MODE_W-1:0] m,
                                        input alf_pkg::t_pos idx,
                                        input alf_pkg::t_word w,
                                        input alf_pkg::t_pos lg);
        t_gen_cmd c;
        c.mode    = m;
        c.index   = idx;
        c.word    = w;
        c.lag_set = lg;
        return c;
    endfunction

    // A position inside the live part of the table, or anywhere when in
    // congruential mode.
    function automatic alf_pkg::t_pos live_pos();
        return (len_cfg == 0) ? alf_pkg::t_pos'($urandom)
                              : alf_pkg::t_pos'($urandom_range(0, len_cfg - 1));
    endfunction

    // Mostly draws, with table writes and position loads mostly aimed at the
    // live words; the remainder is fully random noise including mode 3.
    function automatic t_gen_cmd rand_cmd();
        t_gen_cmd c;
        int r;
        c = mk_cmd(alf_pkg::MODE_DRAW, alf_pkg::t_pos'($urandom), $urandom,
                   alf_pkg::t_pos'($urandom));
        r = $urandom_range(0, 99);
        if (r < 50) begin
            c.mode = alf_pkg::MODE_DRAW;
        end else if (r < 72) begin
            c.mode = alf_pkg::MODE_WRITE;
            if (r < 66) c.index = live_pos();
        end else if (r < 86) begin
            c.mode = alf_pkg::MODE_SETPOS;
            if (r < 82) begin
                c.index   = live_pos();
                c.lag_set = live_pos();
            end
        end else begin
            c.mode = alf_pkg::MODE_W'($urandom_range(0, 3));
        end
        return c;
    endfunction

    // APB transfer: setup at one falling edge, access at the next, done at the
    // rising edge where pready is seen. prdata is sampled at that same edge.
    task automatic cfg_access(input logic wr, input logic [alf_pkg::CFG_ADDR_W-1:0] addr,
                              input logic [alf_pkg::CFG_DATA_W-1:0] wdata,
                              output logic [alf_pkg::CFG_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Only called with the block idle. Upper data bits are junk on purpose on
    // about half the calls; the register keeps six bits.
    task automatic set_table_len(input alf_pkg::t_pos len);
        logic [alf_pkg::CFG_DATA_W-1:0] wdata;
        logic [alf_pkg::CFG_DATA_W-1:0] rdata;
        logic [alf_pkg::CFG_ADDR_W-1:0] addr;
        addr  = {alf_pkg::REG_TABLE_LEN, 2'b00};
        wdata = {(alf_pkg::CFG_DATA_W-alf_pkg::POS_W)'($urandom), len};
        if ($urandom_range(0, 1) == 1) begin
            wdata[alf_pkg::CFG_DATA_W-1:alf_pkg::POS_W] = '0;
        end
        cfg_access(1'b1, addr, wdata, rdata);
        len_cfg = len;
        cfg_access(1'b0, addr, '0, rdata);
        if (rdata[alf_pkg::POS_W-1:0] !== len) begin
            $error("table_len readback: expected %0d, got %0d", len,
                   rdata[alf_pkg::POS_W-1:0]);
            fail_cnt++;
        end
    endtask

    // Block is idle once every command word is taken and every result is in;
    // the extra wait covers the two-stage pipe.
    task automatic wait_idle();
        do @(posedge i_clk); while (cmd_q.size() != 0 || due_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Random phase. Some of the time a well-formed reload is sent: every live
    // word written, both positions aimed inside the table, then a run of draws.
    task automatic fill_random(input int target);
        int counted;
        int n;
        int k;
        t_gen_cmd c;
        counted = 0;
        while (counted < target) begin
            if ($urandom_range(0, 99) < 12 && len_cfg != 0 && len_cfg <= 16) begin
                for (k = 0; k < len_cfg; k++)
                    cmd_q.push_back(mk_cmd(alf_pkg::MODE_WRITE, alf_pkg::t_pos'(k),
                                           $urandom, '0));
                cmd_q.push_back(mk_cmd(alf_pkg::MODE_SETPOS, live_pos(), $urandom,
                                       live_pos()));
                n = $urandom_range(4, 16);
                for (k = 0; k < n; k++)
                    cmd_q.push_back(mk_cmd(alf_pkg::MODE_DRAW, alf_pkg::t_pos'($urandom),
                                           $urandom, alf_pkg::t_pos'($urandom)));
                counted += len_cfg + 1 + n;
            end else begin
                c = rand_cmd();
                cmd_q.push_back(c);
                if (c.mode != MODE_UNUSED) counted++;
            end
        end
        wait_idle();
    endtask

    // Acceptance is seen at the rising edge; the driver acts on it at the
    // following falling edge, so the predictor never races the monitor.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && cmd_if.valid && cmd_if.ready;
    end

    // Driver: predicts the word just taken, then shapes the next one into
    // bursts with random gaps. valid gets a single assignment per edge.
    always @(negedge i_clk) begin
        if (in_taken) begin
            due_q.push_back(step_generator(cmd_q[0]));
            void'(cmd_q.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                          : $urandom_range(1, 10);
            end
        end
        if (gap_left > 0) begin
            gap_left--;
            cmd_if.valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
            cmd_if.valid   <= 1'b1;
            cmd_if.mode    <= cmd_q[0].mode;
            cmd_if.index   <= cmd_q[0].index;
            cmd_if.word    <= cmd_q[0].word;
            cmd_if.lag_set <= cmd_q[0].lag_set;
        end else begin
            cmd_if.valid <= 1'b0;
        end
    end

    // Receiver: switches among always-ready, random, a rotating pattern and
    // long alternating holds, each style for a random stretch.
    always @(negedge i_clk) begin
        if (style_left == 0) begin
            style      = $urandom_range(0, 3);
            style_left = $urandom_range(20, 120);
        end else begin
            style_left--;
        end
        case (style)
            0: rdy_nxt = 1'b1;
            1: rdy_nxt = ($urandom_range(0, 3) != 0);
            2: begin
                stall_pat = {stall_pat[6:0], stall_pat[7]};
                rdy_nxt   = stall_pat[0];
            end
            default: begin
                if (hold_left == 0) begin
                    hold_val  = ~hold_val;
                    hold_left = hold_val ? $urandom_range(3, 25) : $urandom_range(2, 12);
                end else begin
                    hold_left--;
                end
                rdy_nxt = hold_val;
            end
        endcase
        res_if.ready <= rdy_nxt;
    end

    // Monitor: every result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_gen_result exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_q.size() == 0) begin
                $error("result word with nothing predicted: number %h lead %0d lag %0d",
                       res_if.number, res_if.lead_now, res_if.lag_now);
                fail_cnt++;
            end else begin
                exp_r = due_q.pop_front();
                if (res_if.number !== exp_r.number) begin
                    $error("number: expected %h, got %h", exp_r.number, res_if.number);
                    fail_cnt++;
                end
                if (res_if.lead_now !== exp_r.lead_now) begin
                    $error("lead_now: expected %0d, got %0d", exp_r.lead_now, res_if.lead_now);
                    fail_cnt++;
                end
                if (res_if.lag_now !== exp_r.lag_now) begin
                    $error("lag_now: expected %0d, got %0d", exp_r.lag_now, res_if.lag_now);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $error("timed out with %0d words queued and %0d results due",
                   cmd_q.size(), due_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int k;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cmd_if.valid   = 1'b0;
        cmd_if.mode    = alf_pkg::MODE_WRITE;
        cmd_if.index   = '0;
        cmd_if.word    = '0;
        cmd_if.lag_set = '0;
        res_if.ready   = 1'b0;
        in_taken       = 1'b0;
        for (k = 0; k < alf_pkg::TABLE_DEPTH; k++) word_tbl[k] = '0;
        lead_pos = '0;
        lag_pos  = '0;
        len_cfg  = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Congruential mode: steps from a zero seed, from an all-ones seed,
        // ignored mode 3, and a position load that draws must not move.
        set_table_len(6'd0);
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_DRAW, '0, '0, '0));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_DRAW, 6'd63, 32'hFFFF_FFFF, 6'd63));
        cmd_q.push_back(mk_cmd(MODE_UNUSED, 6'd63, 32'hFFFF_FFFF, 6'd63));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_WRITE, 6'd0, 32'hFFFF_FFFF, '0));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_DRAW, '0, '0, '0));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_SETPOS, 6'd63, '0, 6'd63));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_DRAW, '0, '0, '0));
        wait_idle();

        // Largest table: 32-bit wrap of the sum, wrap of both positions at
        // the top, lead and lag on the same word.
        set_table_len(6'd63);
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_WRITE, 6'd62, 32'hFFFF_FFFF, '0));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_WRITE, 6'd63, 32'h0000_0001, 6'd63));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_WRITE, 6'd0, 32'h8000_0000, '0));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_SETPOS, 6'd62, '0, 6'd63));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_DRAW, '0, '0, '0));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_DRAW, '0, '0, '0));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_SETPOS, 6'd0, '0, 6'd0));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_DRAW, '0, '0, '0));
        wait_idle();

        // Short table with positions loaded past its end: they count up to
        // 63, wrap, then cycle inside the table.
        set_table_len(6'd5);
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_SETPOS, 6'd40, '0, 6'd63));
        for (k = 0; k < 4; k++) cmd_q.push_back(mk_cmd(alf_pkg::MODE_DRAW, '0, '0, '0));
        cmd_q.push_back(mk_cmd(MODE_UNUSED, '0, '0, '0));
        cmd_q.push_back(mk_cmd(alf_pkg::MODE_WRITE, 6'd63, '0, '0));
        fill_random(70);

        // Random phases across table lengths, extremes included.
        set_table_len(6'd63);
        fill_random(80);
        set_table_len(6'd1);
        fill_random(60);
        set_table_len(6'd0);
        fill_random(70);
        set_table_len(6'd2);
        fill_random(60);
        set_table_len(alf_pkg::t_pos'($urandom_range(3, 62)));
        fill_random(80);
        set_table_len(6'd9);
        fill_random(70);
        set_table_len(6'd16);
        fill_random(60);

        if (fail_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
